[rtl/xnpop_pkg.sv]
// Shared widths, command codes and pipeline types of the XNOR-popcount matrix product.
package xnpop_pkg;

  // Beat field widths
  localparam int CMD_W      = 2;
  localparam int ROW_W      = 6;
  localparam int COL_W      = 6;
  localparam int WORD_IDX_W = 4;
  localparam int DATA_W     = 64;
  localparam int CFG_W      = 5;
  localparam int COUNT_W    = 11;

  // Command codes
  localparam logic [CMD_W-1:0] CMD_WRITE_A = 2'd0;
  localparam logic [CMD_W-1:0] CMD_WRITE_B = 2'd1;
  localparam logic [CMD_W-1:0] CMD_COMPUTE = 2'd2;

  // Default geometry
  localparam int DEF_ROWS      = 64;
  localparam int DEF_COLS      = 64;
  localparam int DEF_MAX_WORDS = 16;
  localparam int DEF_WORD_BITS = 64;

  localparam logic [CFG_W-1:0] WORDS_RESET = 5'd16;
  localparam int COUNT_MAX  = 2047;
  localparam int OUTQ_DEPTH = 4;

  // Control tag that rides along with each word pair
  typedef struct packed {
    logic             first;
    logic             last;
    logic             zero;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
  } xnpop_tag_t;

  typedef struct packed {
    logic       valid;
    xnpop_tag_t tag;
  } xnpop_issue_t;

  typedef struct packed {
    logic [ROW_W-1:0]   row;
    logic [COL_W-1:0]   col;
    logic [COUNT_W-1:0] count;
  } xnpop_result_t;

endpackage

[rtl/xnpop_ram.sv]
// Simple dual-port word store with registered read.
module xnpop_ram #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 64,
  parameter int AW    = 10
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read port, old data on a same-cycle write
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

[rtl/xnpop_seq.sv]
// Sequencer: walks the word pairs of one compute item, one pair per cycle.
module xnpop_seq #(
  parameter int ROWS      = 64,
  parameter int COLS      = 64,
  parameter int MAX_WORDS = 16,
  parameter int A_AW      = 10,
  parameter int B_AW      = 10
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [xnpop_pkg::ROW_W-1:0]  row,
  input  logic [xnpop_pkg::COL_W-1:0]  column,
  input  logic [xnpop_pkg::CFG_W-1:0]  words_in_use,
  output logic                         ready,
  output xnpop_pkg::xnpop_issue_t      issue,
  output logic [A_AW-1:0]              a_addr,
  output logic [B_AW-1:0]              b_addr
);

  import xnpop_pkg::*;

  localparam int CNT_W = $clog2(MAX_WORDS + 1);

  logic             busy;
  logic             zero_r;
  logic             first_r;
  logic [CNT_W-1:0] left;
  logic [ROW_W-1:0] row_r;
  logic [COL_W-1:0] col_r;
  logic             in_range;
  logic [CNT_W-1:0] used;
  logic             last;

  // Start-up decode
  assign in_range = (32'(row) < ROWS) && (32'(column) < COLS);
  assign used     = (32'(words_in_use) > MAX_WORDS) ? CNT_W'(MAX_WORDS)
                                                    : CNT_W'(words_in_use);

  // Issue slot
  assign last            = zero_r || (left == CNT_W'(1));
  assign issue.valid     = busy;
  assign issue.tag.first = first_r;
  assign issue.tag.last  = last;
  assign issue.tag.zero  = zero_r;
  assign issue.tag.row   = row_r;
  assign issue.tag.col   = col_r;
  assign ready           = !busy || last;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
    end else if (busy && last) begin
      busy <= 1'b0;
    end
  end

  // Word walk: A steps by one, B steps by a row of columns
  always_ff @(posedge clk) begin
    if (start) begin
      zero_r  <= !in_range || (used == '0);
      first_r <= 1'b1;
      left    <= used;
      row_r   <= row;
      col_r   <= column;
      a_addr  <= A_AW'(row * MAX_WORDS);
      b_addr  <= B_AW'(column);
    end else if (busy) begin
      first_r <= 1'b0;
      left    <= left - CNT_W'(1);
      a_addr  <= a_addr + A_AW'(1);
      b_addr  <= b_addr + B_AW'(COLS);
    end
  end

endmodule

[rtl/xnpop_count.sv]
// XNOR-popcount pipeline and per-item accumulator.
module xnpop_count #(
  parameter int MAX_WORDS = 16,
  parameter int WORD_BITS = 64
) (
  input  logic                      clk,
  input  logic                      rst,
  input  xnpop_pkg::xnpop_issue_t   issue,
  input  logic [WORD_BITS-1:0]      a_word,
  input  logic [WORD_BITS-1:0]      b_word,
  output logic                      push,
  output xnpop_pkg::xnpop_result_t  result
);

  import xnpop_pkg::*;

  localparam int CHUNK  = 16;
  localparam int NCHUNK = (WORD_BITS + CHUNK - 1) / CHUNK;
  localparam int PAD_W  = NCHUNK * CHUNK;
  localparam int PART_W = $clog2(CHUNK + 1);
  localparam int WC_W   = $clog2(WORD_BITS + 1);
  localparam int ACC_W  = $clog2(MAX_WORDS * WORD_BITS + 1);

  function automatic logic [PART_W-1:0] popcount16(input logic [CHUNK-1:0] x);
    logic [PART_W-1:0] total;
    total = '0;
    for (int n = 0; n < CHUNK / 4; n++) begin
      total = total + PART_W'(x[4*n]) + PART_W'(x[4*n+1])
                    + PART_W'(x[4*n+2]) + PART_W'(x[4*n+3]);
    end
    return total;
  endfunction

  logic                 v1, v2, v3;
  xnpop_tag_t           tag1, tag2, tag3;
  logic [WORD_BITS-1:0] xnor_w;
  logic [PAD_W-1:0]     agree;
  logic [PART_W-1:0]    part2 [NCHUNK];
  logic [WC_W-1:0]      wc_sum;
  logic [WC_W-1:0]      wc3;
  logic [ACC_W-1:0]     acc;
  logic [ACC_W-1:0]     acc_sum;

  // Valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      v1 <= issue.valid;
      v2 <= v1;
      v3 <= v2;
    end
  end

  // Stage 1: tag lines up with the store read
  always_ff @(posedge clk) begin
    tag1 <= issue.tag;
  end

  // Stage 2: bitwise agreement, counted per 16-bit chunk; pad bits stay zero
  assign xnor_w = ~(a_word ^ b_word);
  assign agree  = PAD_W'(xnor_w);

  always_ff @(posedge clk) begin
    tag2 <= tag1;
    for (int i = 0; i < NCHUNK; i++) begin
      part2[i] <= tag1.zero ? '0 : popcount16(agree[i*CHUNK +: CHUNK]);
    end
  end

  // Stage 3: word count
  always_comb begin
    wc_sum = '0;
    for (int i = 0; i < NCHUNK; i++) begin
      wc_sum = wc_sum + WC_W'(part2[i]);
    end
  end

  always_ff @(posedge clk) begin
    tag3 <= tag2;
    wc3  <= wc_sum;
  end

  // Stage 4: accumulate over the item, hand out on its last word
  assign acc_sum = (tag3.first ? '0 : acc) + ACC_W'(wc3);

  always_ff @(posedge clk) begin
    if (v3) begin
      acc <= acc_sum;
    end
  end

  assign push         = v3 && tag3.last;
  assign result.row   = tag3.row;
  assign result.col   = tag3.col;
  assign result.count = (32'(acc_sum) > COUNT_MAX) ? COUNT_W'(COUNT_MAX)
                                                   : COUNT_W'(acc_sum);

endmodule

[rtl/xnpop_outq.sv]
// Small result queue in front of the master side.
module xnpop_outq (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      push,
  input  xnpop_pkg::xnpop_result_t  push_data,
  input  logic                      pop,
  output logic                      valid,
  output xnpop_pkg::xnpop_result_t  data
);

  import xnpop_pkg::*;

  localparam int PTR_W = $clog2(OUTQ_DEPTH);

  xnpop_result_t    slots [OUTQ_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [PTR_W:0]   fill;

  assign valid = (fill != '0);
  assign data  = slots[rd_ptr];

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + PTR_W'(1);
      end
      fill <= fill + (PTR_W+1)'(push) - (PTR_W+1)'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

endmodule

[rtl/xnor_popcount_matrix_product.sv]
// Top level of the XNOR-popcount binary matrix product.
// Slave beats with tuser 0 or 1 write one packed word of A (row, word) or B (word, column);
// tuser 2 computes element (row, column) as the sum over
// min(words_in_use, MAX_WORDS) words of popcount(~(A ^ B)), saturated at 2047. A compute
// beat holds the input while the sequencer reads one A/B word pair per cycle from the single
// read port of each store; a beat after it is taken in the cycle of the last read.
// Out-of-range row or column, or a word count of zero, gives a zero count. The result goes
// from the store read through the registered chunk counts and word count to the accumulator,
// then into a four-entry queue; the input also holds while four results are outstanding.
// Stores are not cleared at reset: only written words may be read.
module xnor_popcount_matrix_product #(
  parameter int ROWS      = xnpop_pkg::DEF_ROWS,
  parameter int COLS      = xnpop_pkg::DEF_COLS,
  parameter int MAX_WORDS = xnpop_pkg::DEF_MAX_WORDS,
  parameter int WORD_BITS = xnpop_pkg::DEF_WORD_BITS
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_wr_en,
  input  logic [xnpop_pkg::CFG_W-1:0] cfg_wr_data,   // words_in_use
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  input  logic [79:0]                 s_axis_tdata,  // row, column, word_index, data_word
  input  logic [xnpop_pkg::CMD_W-1:0] s_axis_tuser,  // cmd
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  output logic [23:0]                 m_axis_tdata   // out_row, out_column, match_count
);

  import xnpop_pkg::*;

  localparam int A_DEPTH = ROWS * MAX_WORDS;
  localparam int B_DEPTH = MAX_WORDS * COLS;
  localparam int A_AW    = (A_DEPTH > 1) ? $clog2(A_DEPTH) : 1;
  localparam int B_AW    = (B_DEPTH > 1) ? $clog2(B_DEPTH) : 1;
  localparam int PEND_W  = $clog2(OUTQ_DEPTH + 1);

  logic [CFG_W-1:0]      words_in_use;
  logic [ROW_W-1:0]      row;
  logic [COL_W-1:0]      column;
  logic [WORD_IDX_W-1:0] word_index;
  logic [DATA_W-1:0]     data_word;
  logic                  in_beat;
  logic                  out_beat;
  logic                  start;
  logic                  seq_ready;
  logic [PEND_W-1:0]     pending;
  logic                  a_we, b_we;
  logic [A_AW-1:0]       a_waddr, a_raddr;
  logic [B_AW-1:0]       b_waddr, b_raddr;
  logic [WORD_BITS-1:0]  a_word, b_word;
  xnpop_issue_t          issue;
  logic                  res_push;
  xnpop_result_t         res_data;
  xnpop_result_t         q_data;

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      words_in_use <= WORDS_RESET;
    end else if (cfg_wr_en) begin
      words_in_use <= cfg_wr_data;
    end
  end

  // Input beat unpack and decode
  assign row        = s_axis_tdata[5:0];
  assign column     = s_axis_tdata[11:6];
  assign word_index = s_axis_tdata[15:12];
  assign data_word  = s_axis_tdata[79:16];

  assign s_axis_tready = seq_ready && (pending < PEND_W'(OUTQ_DEPTH));
  assign in_beat       = s_axis_tvalid && s_axis_tready;
  assign out_beat      = m_axis_tvalid && m_axis_tready;
  assign start         = in_beat && (s_axis_tuser == CMD_COMPUTE);

  assign a_we    = in_beat && (s_axis_tuser == CMD_WRITE_A)
                && (32'(row) < ROWS) && (32'(word_index) < MAX_WORDS);
  assign b_we    = in_beat && (s_axis_tuser == CMD_WRITE_B)
                && (32'(column) < COLS) && (32'(word_index) < MAX_WORDS);
  assign a_waddr = A_AW'(row * MAX_WORDS + word_index);
  assign b_waddr = B_AW'(word_index * COLS + column);

  // Results issued and not yet taken; bounds queue occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else begin
      pending <= pending + PEND_W'(start) - PEND_W'(out_beat);
    end
  end

  xnpop_seq #(
    .ROWS      (ROWS),
    .COLS      (COLS),
    .MAX_WORDS (MAX_WORDS),
    .A_AW      (A_AW),
    .B_AW      (B_AW)
  ) u_seq (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .row          (row),
    .column       (column),
    .words_in_use (words_in_use),
    .ready        (seq_ready),
    .issue        (issue),
    .a_addr       (a_raddr),
    .b_addr       (b_raddr)
  );

  xnpop_ram #(
    .DEPTH (A_DEPTH),
    .WIDTH (WORD_BITS),
    .AW    (A_AW)
  ) u_a_store (
    .clk     (clk),
    .wr_en   (a_we),
    .wr_addr (a_waddr),
    .wr_data (data_word[WORD_BITS-1:0]),
    .rd_en   (issue.valid && !issue.tag.zero),
    .rd_addr (a_raddr),
    .rd_data (a_word)
  );

  xnpop_ram #(
    .DEPTH (B_DEPTH),
    .WIDTH (WORD_BITS),
    .AW    (B_AW)
  ) u_b_store (
    .clk     (clk),
    .wr_en   (b_we),
    .wr_addr (b_waddr),
    .wr_data (data_word[WORD_BITS-1:0]),
    .rd_en   (issue.valid && !issue.tag.zero),
    .rd_addr (b_raddr),
    .rd_data (b_word)
  );

  xnpop_count #(
    .MAX_WORDS (MAX_WORDS),
    .WORD_BITS (WORD_BITS)
  ) u_count (
    .clk    (clk),
    .rst    (rst),
    .issue  (issue),
    .a_word (a_word),
    .b_word (b_word),
    .push   (res_push),
    .result (res_data)
  );

  xnpop_outq u_outq (
    .clk       (clk),
    .rst       (rst),
    .push      (res_push),
    .push_data (res_data),
    .pop       (out_beat),
    .valid     (m_axis_tvalid),
    .data      (q_data)
  );

  // Output beat pack
  assign m_axis_tdata = {1'b0, q_data.count, q_data.col, q_data.row};

`ifndef SYNTH
  // A result only leaves the pipeline for an outstanding compute
  assert property (@(posedge clk) disable iff (rst) res_push |-> (pending != '0))
    else $error("result pushed with no compute outstanding");

  // Nothing is shown on the master side without an outstanding compute
  assert property (@(posedge clk) disable iff (rst) m_axis_tvalid |-> (pending != '0))
    else $error("output valid with no compute outstanding");

  // A word walk runs without gaps until its last word
  assert property (@(posedge clk) disable iff (rst)
                   (issue.valid && !issue.tag.last) |=> issue.valid)
    else $error("word walk broke off before its last word");
`endif

endmodule
